// File: rtl/vtot_pkg.sv
// vtot_pkg: shared types, constants and helpers of the voxel template offset tracker
// used by vtot_issue, vtot_score and voxel_template_offset_tracker_core
// no dependencies
package vtot_pkg;

  localparam int NUM_SHIFTS    = 5;
  localparam int K_W           = 3;
  localparam int CENTER_OFFSET = 100;
  localparam int COORD_W       = 24;
  localparam int FRAC_W        = 8;
  localparam int SCORE_W       = 24;
  localparam int POS_W         = 16;
  localparam int IN_DATA_W     = 104;
  localparam int OUT_DATA_W    = 64;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // item kinds carried on tuser
  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef logic [K_W-1:0] shift_idx_t;

  // candidate shifts in scan order
  localparam shift_idx_t SH_CENTER = 3'd0;
  localparam shift_idx_t SH_XNEG   = 3'd1;
  localparam shift_idx_t SH_XPOS   = 3'd2;
  localparam shift_idx_t SH_YNEG   = 3'd3;
  localparam shift_idx_t SH_YPOS   = 3'd4;

  localparam logic signed [1:0] STEP_NEG  = -2'sd1;
  localparam logic signed [1:0] STEP_ZERO = 2'sd0;
  localparam logic signed [1:0] STEP_POS  = 2'sd1;

  typedef struct packed {
    logic [2:0]               pad;
    logic [7:0]               voxel_weight;
    logic [4:0]               voxel_z;
    logic [7:0]               voxel_y;
    logic [7:0]               voxel_x;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
  } in_data_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_x;
    logic                    converged;
    logic [SCORE_W-1:0]      best_score;
    logic signed [1:0]       best_dy;
    logic signed [1:0]       best_dx;
  } res_t;

  // tag that travels alongside a template read
  typedef struct packed {
    logic       vld;
    logic       hit;
    logic       last;
    shift_idx_t k;
  } rd_tag_t;

  function automatic int idx_bits(input int n);
    idx_bits = (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic signed [1:0] shift_dx(input shift_idx_t k);
    case (k)
      SH_XNEG: shift_dx = STEP_NEG;
      SH_XPOS: shift_dx = STEP_POS;
      default: shift_dx = STEP_ZERO;
    endcase
  endfunction

  function automatic logic signed [1:0] shift_dy(input shift_idx_t k);
    case (k)
      SH_YNEG: shift_dy = STEP_NEG;
      SH_YPOS: shift_dy = STEP_POS;
      default: shift_dy = STEP_ZERO;
    endcase
  endfunction

endpackage

// File: rtl/vtot_tmpl_ram.sv
// vtot_tmpl_ram: template weight memory, one write and one registered read per cycle
// no package dependencies
module vtot_tmpl_ram #(
  parameter int ADDR_W = 21,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/vtot_issue.sv
// vtot_issue: input item register, voxel address generation, template writes and
// the clearing pass after reset; depends on vtot_pkg
module vtot_issue #(
  parameter int GRID_X      = 256,
  parameter int GRID_Y      = 256,
  parameter int GRID_Z      = 32,
  parameter int WEIGHT_BITS = 8,
  localparam int ADDR_W     = vtot_pkg::idx_bits(GRID_X) + vtot_pkg::idx_bits(GRID_Y)
                              + vtot_pkg::idx_bits(GRID_Z)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [vtot_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  input  logic signed [vtot_pkg::POS_W-1:0]  track_x,
  input  logic signed [vtot_pkg::POS_W-1:0]  track_y,
  input  logic                               lock,
  output logic                               mem_we,
  output logic [ADDR_W-1:0]                  mem_waddr,
  output logic [WEIGHT_BITS-1:0]             mem_wdata,
  output logic [ADDR_W-1:0]                  mem_raddr,
  output vtot_pkg::rd_tag_t                  tag
);

  import vtot_pkg::*;

  localparam int XW  = idx_bits(GRID_X);
  localparam int YW  = idx_bits(GRID_Y);
  localparam int ZW  = idx_bits(GRID_Z);
  localparam int SW  = COORD_W + 3;  // shifted coordinate in fixed point
  localparam int QW  = SW - FRAC_W;  // whole voxel index
  localparam int WHW = SW - FRAC_W;  // whole-cm offset

  function automatic logic signed [QW-1:0] trunc_idx(input logic signed [SW-1:0] s);
    logic signed [QW-1:0] q;
    q = s[SW-1:FRAC_W];
    // floor to truncation for negative values with a fraction
    if (s[SW-1] && (|s[FRAC_W-1:0])) begin
      q = q + QW'(1);
    end
    trunc_idx = q;
  endfunction

  in_data_t din;
  assign din = in_data_t'(in_tdata);

  logic                      a_vld_r;
  logic                      a_mode_r;
  logic                      a_last_r;
  logic signed [COORD_W-1:0] a_x_r, a_y_r, a_z_r;
  logic [7:0]                a_vx_r, a_vy_r;
  logic [4:0]                a_vz_r;
  logic [7:0]                a_w_r;
  shift_idx_t                k_r;

  logic              clr_done_r;
  logic [ADDR_W-1:0] clr_addr_r;
  rd_tag_t           tag_r, tag_nxt;

  logic go, a_fin, accept;
  logic signed [WHW-1:0] wh_x, wh_y;
  logic signed [SW-1:0]  s_x, s_y, s_z;
  logic signed [QW-1:0]  tx, ty, tz;
  logic                  hit, wr_ok;

  assign go     = a_vld_r && !lock && clr_done_r;
  assign a_fin  = (a_mode_r == MODE_WRITE) || (k_r == SH_YPOS);
  assign in_tready = clr_done_r && (!a_vld_r || (go && a_fin));
  assign accept = in_tvalid && in_tready;

  always_comb begin
    wh_x = WHW'(shift_dx(k_r)) - WHW'(track_x) + WHW'(CENTER_OFFSET);
    wh_y = WHW'(shift_dy(k_r)) - WHW'(track_y) + WHW'(CENTER_OFFSET);
    s_x  = SW'(a_x_r) + SW'($signed({wh_x, {FRAC_W{1'b0}}}));
    s_y  = SW'(a_y_r) + SW'($signed({wh_y, {FRAC_W{1'b0}}}));
    s_z  = SW'(a_z_r);
    tx   = trunc_idx(s_x);
    ty   = trunc_idx(s_y);
    tz   = trunc_idx(s_z);
    hit  = !tx[QW-1] && (tx < QW'(GRID_X)) &&
           !ty[QW-1] && (ty < QW'(GRID_Y)) &&
           !tz[QW-1] && (tz < QW'(GRID_Z));
    wr_ok = (32'(a_vx_r) < GRID_X) && (32'(a_vy_r) < GRID_Y) && (32'(a_vz_r) < GRID_Z);
  end

  assign mem_raddr = {tx[XW-1:0], ty[YW-1:0], tz[ZW-1:0]};

  always_comb begin
    if (!clr_done_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = go && (a_mode_r == MODE_WRITE) && wr_ok;
      mem_waddr = {XW'(a_vx_r), YW'(a_vy_r), ZW'(a_vz_r)};
      mem_wdata = WEIGHT_BITS'(a_w_r);
    end
  end

  always_comb begin
    tag_nxt.vld  = go && (a_mode_r == MODE_POINT);
    tag_nxt.hit  = hit;
    tag_nxt.last = a_last_r && (k_r == SH_YPOS);
    tag_nxt.k    = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r    <= 1'b0;
      k_r        <= SH_CENTER;
      clr_done_r <= 1'b0;
      clr_addr_r <= '0;
      tag_r      <= '0;
    end else begin
      tag_r <= tag_nxt;
      if (!clr_done_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == {ADDR_W{1'b1}}) begin
          clr_done_r <= 1'b1;
        end
      end
      if (go) begin
        if (a_fin) begin
          a_vld_r <= 1'b0;
        end else begin
          k_r <= k_r + K_W'(1);
        end
      end
      if (accept) begin
        a_vld_r <= 1'b1;
        k_r     <= SH_CENTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mode_r <= in_tuser;
      a_last_r <= in_tlast;
      a_x_r    <= din.point_x;
      a_y_r    <= din.point_y;
      a_z_r    <= din.point_z;
      a_vx_r   <= din.voxel_x;
      a_vy_r   <= din.voxel_y;
      a_vz_r   <= din.voxel_z;
      a_w_r    <= din.voxel_weight;
    end
  end

  assign tag = tag_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !in_tready)
    else $error("item accepted during clearing pass");

  a_lock_stops_reads: assert property (@(posedge clk) disable iff (!rst_n)
    lock |=> !tag_r.vld)
    else $error("template read issued while a frame result is pending");

  a_write_only_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && clr_done_r) |-> (go && (a_mode_r == MODE_WRITE)))
    else $error("template write without a write item");

endmodule

// File: rtl/vtot_score.sv
// vtot_score: per-shift score accumulation, best-shift ranking, tracked position
// and the result register; depends on vtot_pkg
module vtot_score #(
  parameter int WEIGHT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vtot_pkg::rd_tag_t                  tag_i,
  input  logic [WEIGHT_BITS-1:0]             rd_data,
  output logic                               lock,
  output logic signed [vtot_pkg::POS_W-1:0]  track_x,
  output logic signed [vtot_pkg::POS_W-1:0]  track_y,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [vtot_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import vtot_pkg::*;

  logic [SCORE_W-1:0] sum_r [NUM_SHIFTS];
  logic [SCORE_W:0]   add_v [NUM_SHIFTS];

  logic               fin1_r, fin2_r;
  shift_idx_t         idx_a_r, idx_b_r;
  logic [SCORE_W-1:0] sc_a_r, sc_b_r, sc_4_r;

  logic signed [POS_W-1:0] track_x_r, track_y_r;
  logic                    out_valid_r;
  res_t                    out_data_r;

  logic               slot_free, fin_go;
  shift_idx_t         idx_ab, best_idx;
  logic [SCORE_W-1:0] sc_ab, best_sc;
  logic signed [1:0]  bdx, bdy;
  logic signed [POS_W:0] dpx, dpy;
  logic signed [POS_W-1:0] npx, npy;
  res_t               res_nxt;

  assign slot_free = !out_valid_r || out_tready;
  assign fin_go    = fin2_r && slot_free;
  assign lock      = (tag_i.vld && tag_i.last) || fin1_r || fin2_r;

  always_comb begin
    for (int e = 0; e < NUM_SHIFTS; e++) begin
      add_v[e] = {1'b0, sum_r[e]} + (SCORE_W + 1)'(rd_data);
    end
  end

  // accumulate; sums clear once the pair ranking has captured them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < NUM_SHIFTS; e++) begin
        sum_r[e] <= '0;
      end
    end else if (fin1_r) begin
      for (int e = 0; e < NUM_SHIFTS; e++) begin
        sum_r[e] <= '0;
      end
    end else if (tag_i.vld && tag_i.hit) begin
      for (int e = 0; e < NUM_SHIFTS; e++) begin
        if (tag_i.k == K_W'(e)) begin
          sum_r[e] <= add_v[e][SCORE_W] ? SCORE_MAX : add_v[e][SCORE_W-1:0];
        end
      end
    end
  end

  // first ranking stage: two pairs, later index wins only when strictly greater
  always_ff @(posedge clk) begin
    if (fin1_r) begin
      idx_a_r <= (sum_r[SH_XNEG] > sum_r[SH_CENTER]) ? SH_XNEG : SH_CENTER;
      sc_a_r  <= (sum_r[SH_XNEG] > sum_r[SH_CENTER]) ? sum_r[SH_XNEG] : sum_r[SH_CENTER];
      idx_b_r <= (sum_r[SH_YNEG] > sum_r[SH_XPOS]) ? SH_YNEG : SH_XPOS;
      sc_b_r  <= (sum_r[SH_YNEG] > sum_r[SH_XPOS]) ? sum_r[SH_YNEG] : sum_r[SH_XPOS];
      sc_4_r  <= sum_r[SH_YPOS];
    end
  end

  always_comb begin
    idx_ab   = (sc_b_r > sc_a_r) ? idx_b_r : idx_a_r;
    sc_ab    = (sc_b_r > sc_a_r) ? sc_b_r : sc_a_r;
    best_idx = (sc_4_r > sc_ab) ? SH_YPOS : idx_ab;
    best_sc  = (sc_4_r > sc_ab) ? sc_4_r : sc_ab;
    bdx      = shift_dx(best_idx);
    bdy      = shift_dy(best_idx);
    dpx      = (POS_W + 1)'(track_x_r) - (POS_W + 1)'(bdx);
    dpy      = (POS_W + 1)'(track_y_r) - (POS_W + 1)'(bdy);
    // saturate when the top two bits disagree
    if (dpx[POS_W] != dpx[POS_W-1]) begin
      npx = dpx[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      npx = dpx[POS_W-1:0];
    end
    if (dpy[POS_W] != dpy[POS_W-1]) begin
      npy = dpy[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      npy = dpy[POS_W-1:0];
    end
    res_nxt.best_dx    = bdx;
    res_nxt.best_dy    = bdy;
    res_nxt.best_score = best_sc;
    res_nxt.converged  = (best_idx == SH_CENTER);
    res_nxt.position_x = npx;
    res_nxt.position_y = npy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin1_r      <= 1'b0;
      fin2_r      <= 1'b0;
      track_x_r   <= '0;
      track_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fin1_r <= tag_i.vld && tag_i.last;
      if (fin1_r) begin
        fin2_r <= 1'b1;
      end else if (fin_go) begin
        fin2_r <= 1'b0;
      end
      if (fin_go) begin
        track_x_r   <= npx;
        track_y_r   <= npy;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= res_nxt;
    end
  end

  assign track_x    = track_x_r;
  assign track_y    = track_y_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);

  a_no_score_while_ranking: assert property (@(posedge clk) disable iff (!rst_n)
    fin1_r |-> !tag_i.vld)
    else $error("point scored while the frame is being ranked");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    fin1_r |=> (sum_r[0] == '0) && (sum_r[1] == '0) && (sum_r[2] == '0) &&
               (sum_r[3] == '0) && (sum_r[4] == '0))
    else $error("scores not cleared after frame end");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r && !fin2_r)
    else $error("frame result not presented");

endmodule

// File: rtl/voxel_template_offset_tracker_core.sv
// voxel_template_offset_tracker_core: top level of the voxel template offset tracker
// depends on vtot_pkg, vtot_issue, vtot_score and vtot_tmpl_ram
//
//   channel | direction | contents
//   in_     | slave     | tuser = mode (1 = template write), tlast = last point of frame,
//           |           | tdata = point xyz and voxel write fields
//   out_    | master    | tdata = best shift, score, converged flag, tracked position
//
// a cloud point issues one template memory read per candidate shift on the
// single read port; a template write issues a single memory write
// the last point of a frame holds back the next item during ranking and position
// update, and longer while the result register is still held by out_tready low
// after reset a clearing pass writes zeros to all 2**(address bits) template entries
// (2097152 entries at default grid size) with in_tready low
// one result waits in the output register while further items are taken
module voxel_template_offset_tracker_core #(
  parameter int GRID_X      = 256,
  parameter int GRID_Y      = 256,
  parameter int GRID_Z      = 32,
  parameter int WEIGHT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // point_x, point_y, point_z, voxel_x, voxel_y, voxel_z, voxel_weight, zero pad
  input  logic [vtot_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // best_dx, best_dy, best_score, converged, position_x, position_y, zero pad
  output logic [vtot_pkg::OUT_DATA_W-1:0] out_tdata
);

  import vtot_pkg::*;

  localparam int ADDR_W = idx_bits(GRID_X) + idx_bits(GRID_Y) + idx_bits(GRID_Z);

  logic                    lock;
  logic signed [POS_W-1:0] track_x, track_y;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
  logic [WEIGHT_BITS-1:0]  mem_wdata, mem_rdata;
  rd_tag_t                 tag;

  vtot_issue #(
    .GRID_X      (GRID_X),
    .GRID_Y      (GRID_Y),
    .GRID_Z      (GRID_Z),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .track_x   (track_x),
    .track_y   (track_y),
    .lock      (lock),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .tag       (tag)
  );

  vtot_tmpl_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (WEIGHT_BITS)
  ) u_tmpl_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  vtot_score #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag_i      (tag),
    .rd_data    (mem_rdata),
    .lock       (lock),
    .track_x    (track_x),
    .track_y    (track_y),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
